/* hdl/mbtcp_pkg.sv */
// Shared types and constants for the Modbus TCP request parser.
// Holds parse phase codes, result kinds, function codes and the result record.
// No dependencies.
`timescale 1ns / 1ps

package mbtcp_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 64;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

    localparam logic [CFG_INDEX_W-1:0] REG_UNIT_ADDRESS    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VALID_CODE_MASK = 1'd1;

    localparam logic [7:0]  UNIT_ADDRESS_RESET    = 8'd0;
    localparam logic [63:0] VALID_CODE_MASK_RESET = 64'd8487038;

    localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
    localparam logic [7:0] FC_WRITE_REGISTERS = 8'd16;
    localparam logic [7:0] FC_READ_WRITE_REGS = 8'd23;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_NONSENSE = 2'd2;

    typedef enum logic [17:0] {
        PH_TID_HI  = 18'b000000000000000001,
        PH_TID_LO  = 18'b000000000000000010,
        PH_PROT_HI = 18'b000000000000000100,
        PH_PROT_LO = 18'b000000000000001000,
        PH_LEN_HI  = 18'b000000000000010000,
        PH_LEN_LO  = 18'b000000000000100000,
        PH_UNIT    = 18'b000000000001000000,
        PH_CODE    = 18'b000000000010000000,
        PH_W1_HI   = 18'b000000000100000000,
        PH_W1_LO   = 18'b000000001000000000,
        PH_W2_HI   = 18'b000000010000000000,
        PH_W2_LO   = 18'b000000100000000000,
        PH_W3_HI   = 18'b000001000000000000,
        PH_W3_LO   = 18'b000010000000000000,
        PH_W4_HI   = 18'b000100000000000000,
        PH_W4_LO   = 18'b001000000000000000,
        PH_COUNT   = 18'b010000000000000000,
        PH_DATA    = 18'b100000000000000000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        last_of_run;
        logic [15:0] transaction_id;
        logic [7:0]  function_code;
        logic [15:0] first_value;
        logic [15:0] second_value;
        logic [15:0] third_value;
        logic [15:0] fourth_value;
        logic [7:0]  byte_count;
        logic [7:0]  data_out;
    } result_t;

endpackage

/* hdl/modbus_tcp_request_parser.sv */
// Modbus TCP request parser top level: byte-wide state machine and result queue.
// Depends on mbtcp_pkg.
//
// Usage: bytes of a request stream enter on the in_valid/in_ready channel with
// data_byte and chunk_end; one transfer carries one byte. Results leave on the
// out_valid/out_ready channel, one result record per transfer. A byte causes
// zero, one or two results (the last data byte of a request is followed by a
// request-complete result).
// Each result is written into the result queue when its byte is taken.
// Throughput: one byte per cycle while in_ready is high; the result queue drains
// one record per cycle while out_ready is high, so a request's final data byte
// yields two records, absorbed by the four-entry result queue. in_ready is high
// while at least two queue entries are free.
// Configuration: cfg_we writes unit_address (index 0) or valid_code_mask
// (index 1) from cfg_data; the user must write only while the block is idle,
// which the block itself does not enforce. Reset: the parser returns to the
// transaction id phase; held fields and queue clear; registers get defaults.
// Stall: while out_ready is low, results stay queued; once the queue holds
// more than two entries, in_ready drops until the receiver takes results.
`timescale 1ns / 1ps

module modbus_tcp_request_parser
    import mbtcp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   chunk_end,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             kind,
    output logic                   last_of_run,
    output logic [15:0]            transaction_id,
    output logic [7:0]             function_code,
    output logic [15:0]            first_value,
    output logic [15:0]            second_value,
    output logic [15:0]            third_value,
    output logic [15:0]            fourth_value,
    output logic [7:0]             byte_count,
    output logic [7:0]             data_out
);

    logic [7:0]  unit_address_reg;
    logic [63:0] valid_code_mask_reg;

    phase_t      phase_reg, phase_next;
    logic        dropping_reg, dropping_next;
    logic [15:0] held_transaction_reg, held_transaction_next;
    logic [7:0]  held_code_reg, held_code_next;
    logic [7:0]  high_byte_hold_reg, high_byte_hold_next;
    logic [15:0] held_words_reg [4];
    logic [15:0] held_words_next [4];
    logic [7:0]  held_count_reg, held_count_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;

    result_t                fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wptr_reg, rptr_reg;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;

    logic        take;
    logic        pop;
    logic [1:0]  n_push;
    logic [1:0]  kind0, kind1;
    logic [7:0]  data0;
    logic        last0;
    logic [7:0]  bytes_dec;
    logic        code_ok;
    result_t     res0, res1, head;

    assign in_ready = (count_reg < FIFO_CNT_W'(FIFO_DEPTH - 1));
    assign take     = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign pop      = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_address_reg    <= UNIT_ADDRESS_RESET;
            valid_code_mask_reg <= VALID_CODE_MASK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_UNIT_ADDRESS:    unit_address_reg    <= cfg_data[7:0];
                REG_VALID_CODE_MASK: valid_code_mask_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign bytes_dec = bytes_left_reg - 8'd1;
    assign code_ok   = (data_byte[7:6] == 2'b00) && valid_code_mask_reg[data_byte[5:0]];

    always_comb
    begin
        phase_next            = phase_reg;
        dropping_next         = dropping_reg;
        held_transaction_next = held_transaction_reg;
        held_code_next        = held_code_reg;
        high_byte_hold_next   = high_byte_hold_reg;
        held_words_next       = held_words_reg;
        held_count_next       = held_count_reg;
        bytes_left_next       = bytes_left_reg;
        n_push                = 2'd0;
        kind0                 = KIND_COMPLETE;
        kind1                 = KIND_COMPLETE;
        data0                 = 8'd0;
        last0                 = 1'b1;

        if (dropping_reg)
        begin
            if (chunk_end)
                dropping_next = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_TID_LO:
                begin
                    held_transaction_next = {held_transaction_reg[15:8], data_byte};
                    phase_next = PH_PROT_HI;
                end
                PH_PROT_HI: phase_next = PH_PROT_LO;
                PH_PROT_LO: phase_next = PH_LEN_HI;
                PH_LEN_HI:  phase_next = PH_LEN_LO;
                PH_LEN_LO:  phase_next = PH_UNIT;
                PH_UNIT:
                begin
                    if (data_byte != unit_address_reg)
                    begin
                        phase_next    = PH_TID_HI;
                        dropping_next = !chunk_end;
                    end
                    else
                        phase_next = PH_CODE;
                end
                PH_CODE:
                begin
                    if (code_ok)
                    begin
                        held_code_next = data_byte;
                        phase_next     = PH_W1_HI;
                    end
                    else
                    begin
                        n_push        = 2'd1;
                        kind0         = KIND_NONSENSE;
                        phase_next    = PH_TID_HI;
                        dropping_next = !chunk_end;
                    end
                end
                PH_W1_HI:
                begin
                    high_byte_hold_next = data_byte;
                    phase_next = PH_W1_LO;
                end
                PH_W2_HI:
                begin
                    high_byte_hold_next = data_byte;
                    phase_next = PH_W2_LO;
                end
                PH_W3_HI:
                begin
                    high_byte_hold_next = data_byte;
                    phase_next = PH_W3_LO;
                end
                PH_W4_HI:
                begin
                    high_byte_hold_next = data_byte;
                    phase_next = PH_W4_LO;
                end
                PH_W1_LO:
                begin
                    held_words_next[0] = {high_byte_hold_reg, data_byte};
                    phase_next = PH_W2_HI;
                end
                PH_W2_LO:
                begin
                    held_words_next[1] = {high_byte_hold_reg, data_byte};
                    if (held_code_reg == FC_READ_WRITE_REGS)
                        phase_next = PH_W3_HI;
                    else if (held_code_reg == FC_WRITE_COILS
                             || held_code_reg == FC_WRITE_REGISTERS)
                        phase_next = PH_COUNT;
                    else
                    begin
                        n_push     = 2'd1;
                        phase_next = PH_TID_HI;
                    end
                end
                PH_W3_LO:
                begin
                    held_words_next[2] = {high_byte_hold_reg, data_byte};
                    phase_next = PH_W4_HI;
                end
                PH_W4_LO:
                begin
                    held_words_next[3] = {high_byte_hold_reg, data_byte};
                    phase_next = PH_COUNT;
                end
                PH_COUNT:
                begin
                    held_count_next = data_byte;
                    bytes_left_next = data_byte;
                    if (data_byte == 8'd0)
                    begin
                        n_push     = 2'd1;
                        phase_next = PH_TID_HI;
                    end
                    else
                        phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    kind0           = KIND_DATA;
                    data0           = data_byte;
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 8'd0)
                    begin
                        n_push     = 2'd2;
                        last0      = 1'b0;
                        phase_next = PH_TID_HI;
                    end
                    else
                        n_push = 2'd1;
                end
                default:
                begin
                    held_transaction_next = {data_byte, held_transaction_reg[7:0]};
                    phase_next = PH_TID_LO;
                end
            endcase
        end
    end

    always_comb
    begin
        res0.kind           = kind0;
        res0.last_of_run    = last0;
        res0.transaction_id = held_transaction_next;
        res0.function_code  = held_code_next;
        res0.first_value    = held_words_next[0];
        res0.second_value   = held_words_next[1];
        res0.third_value    = held_words_next[2];
        res0.fourth_value   = held_words_next[3];
        res0.byte_count     = held_count_next;
        res0.data_out       = data0;
        res1                = res0;
        res1.kind           = kind1;
        res1.last_of_run    = 1'b1;
        res1.data_out       = 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_TID_HI;
            dropping_reg         <= 1'b0;
            held_transaction_reg <= '0;
            held_code_reg        <= '0;
            high_byte_hold_reg   <= '0;
            held_count_reg       <= '0;
            bytes_left_reg       <= '0;
            for (int i = 0; i < 4; i++)
                held_words_reg[i] <= '0;
        end
        else if (take)
        begin
            phase_reg            <= phase_next;
            dropping_reg         <= dropping_next;
            held_transaction_reg <= held_transaction_next;
            held_code_reg        <= held_code_next;
            high_byte_hold_reg   <= high_byte_hold_next;
            held_count_reg       <= held_count_next;
            bytes_left_reg       <= bytes_left_next;
            held_words_reg       <= held_words_next;
        end
    end

    assign count_next = count_reg
                        + (take ? FIFO_CNT_W'(n_push) : '0)
                        - FIFO_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (pop)
                rptr_reg <= rptr_reg + FIFO_PTR_W'(1);
            if (take)
                wptr_reg <= wptr_reg + FIFO_PTR_W'(n_push);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && n_push != 2'd0)
            fifo_reg[wptr_reg] <= res0;
        if (take && n_push == 2'd2)
            fifo_reg[wptr_reg + FIFO_PTR_W'(1)] <= res1;
    end

    assign head           = fifo_reg[rptr_reg];
    assign kind           = head.kind;
    assign last_of_run    = head.last_of_run;
    assign transaction_id = head.transaction_id;
    assign function_code  = head.function_code;
    assign first_value    = head.first_value;
    assign second_value   = head.second_value;
    assign third_value    = head.third_value;
    assign fourth_value   = head.fourth_value;
    assign byte_count     = head.byte_count;
    assign data_out       = head.data_out;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("parse phase not one-hot");

    a_drop_phase: assert property (@(posedge clk) disable iff (!rst_n)
        dropping_reg |-> phase_reg == PH_TID_HI)
        else $error("dropping outside transaction id phase");

    a_nonsense_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_NONSENSE |-> last_of_run && data_out == 8'd0)
        else $error("nonsense result malformed");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        take && n_push == 2'd2 |=> count_reg >= FIFO_CNT_W'(1))
        else $error("double push lost");

endmodule

/* dv/modbus_tcp_request_parser_test.sv */
// Self-checking testbench for modbus_tcp_request_parser: feeds request byte streams
// and checks each result record against a byte-level parse tracker.
// Depends on mbtcp_pkg and the parser RTL.
`timescale 1ns / 1ps

module modbus_tcp_request_parser_test
    import mbtcp_pkg::*;
();

    localparam logic [7:0] FC_READ_HOLDING = 8'd3;
    localparam logic [7:0] FC_READ_INPUT   = 8'd4;
    localparam logic [7:0] CODE_LOWEST     = 8'd0;
    localparam logic [7:0] CODE_MASK_TOP   = 8'd63;
    localparam logic [7:0] CODE_PAST_MASK  = 8'd64;
    localparam logic [7:0] CODE_HIGHEST    = 8'd255;

    class adu_tracker;
        logic [7:0]  unit_addr;
        logic [63:0] code_mask;
        phase_t      phase;
        bit          dropping;
        logic [15:0] tid;
        logic [7:0]  code;
        logic [7:0]  hi_hold;
        logic [15:0] words [4];
        logic [7:0]  count;
        logic [7:0]  left;
        result_t     awaited [$];
        int          mismatches;
        int          checked;

        function new();
            unit_addr  = UNIT_ADDRESS_RESET;
            code_mask  = VALID_CODE_MASK_RESET;
            phase      = PH_TID_HI;
            dropping   = 1'b0;
            tid        = '0;
            code       = '0;
            hi_hold    = '0;
            foreach (words[i]) words[i] = '0;
            count      = '0;
            left       = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] value);
            if (idx == REG_UNIT_ADDRESS)
                unit_addr = value[7:0];
            else if (idx == REG_VALID_CODE_MASK)
                code_mask = value;
        endfunction

        function void push_record(logic [1:0] k, logic [7:0] data);
            result_t r;
            r.kind           = k;
            r.last_of_run    = 1'b0;
            r.transaction_id = tid;
            r.function_code  = code;
            r.first_value    = words[0];
            r.second_value   = words[1];
            r.third_value    = words[2];
            r.fourth_value   = words[3];
            r.byte_count     = count;
            r.data_out       = data;
            awaited = {awaited, r};
        endfunction

        function void take_byte(logic [7:0] b, logic e);
            int      before_n;
            result_t r;
            before_n = awaited.size();
            if (dropping)
            begin
                if (e)
                    dropping = 1'b0;
                return;
            end
            case (phase)
                PH_TID_LO:
                begin
                    tid[7:0] = b;
                    phase = PH_PROT_HI;
                end
                PH_PROT_HI: phase = PH_PROT_LO;
                PH_PROT_LO: phase = PH_LEN_HI;
                PH_LEN_HI:  phase = PH_LEN_LO;
                PH_LEN_LO:  phase = PH_UNIT;
                PH_UNIT:
                begin
                    if (b != unit_addr)
                    begin
                        phase = PH_TID_HI;
                        dropping = !e;
                    end
                    else
                        phase = PH_CODE;
                end
                PH_CODE:
                begin
                    if (b < CODE_PAST_MASK && code_mask[b[5:0]])
                    begin
                        code = b;
                        phase = PH_W1_HI;
                    end
                    else
                    begin
                        push_record(KIND_NONSENSE, 8'h00);
                        phase = PH_TID_HI;
                        dropping = !e;
                    end
                end
                PH_W1_HI:
                begin
                    hi_hold = b;
                    phase = PH_W1_LO;
                end
                PH_W2_HI:
                begin
                    hi_hold = b;
                    phase = PH_W2_LO;
                end
                PH_W3_HI:
                begin
                    hi_hold = b;
                    phase = PH_W3_LO;
                end
                PH_W4_HI:
                begin
                    hi_hold = b;
                    phase = PH_W4_LO;
                end
                PH_W1_LO:
                begin
                    words[0] = {hi_hold, b};
                    phase = PH_W2_HI;
                end
                PH_W2_LO:
                begin
                    words[1] = {hi_hold, b};
                    if (code == FC_READ_WRITE_REGS)
                        phase = PH_W3_HI;
                    else if (code == FC_WRITE_COILS || code == FC_WRITE_REGISTERS)
                        phase = PH_COUNT;
                    else
                    begin
                        push_record(KIND_COMPLETE, 8'h00);
                        phase = PH_TID_HI;
                    end
                end
                PH_W3_LO:
                begin
                    words[2] = {hi_hold, b};
                    phase = PH_W4_HI;
                end
                PH_W4_LO:
                begin
                    words[3] = {hi_hold, b};
                    phase = PH_COUNT;
                end
                PH_COUNT:
                begin
                    count = b;
                    left = b;
                    if (b == 8'd0)
                    begin
                        push_record(KIND_COMPLETE, 8'h00);
                        phase = PH_TID_HI;
                    end
                    else
                        phase = PH_DATA;
                end
                PH_DATA:
                begin
                    push_record(KIND_DATA, b);
                    left = left - 8'd1;
                    if (left == 8'd0)
                    begin
                        push_record(KIND_COMPLETE, 8'h00);
                        phase = PH_TID_HI;
                    end
                end
                default:
                begin
                    tid[15:8] = b;
                    phase = PH_TID_LO;
                end
            endcase
            if (awaited.size() > before_n)
            begin
                r = awaited[awaited.size() - 1];
                r.last_of_run = 1'b1;
                awaited[awaited.size() - 1] = r;
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_record(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: kind %0d data 0x%0h", got.kind, got.data_out);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            compare_field("kind", want.kind, got.kind);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
            compare_field("transaction_id", want.transaction_id, got.transaction_id);
            compare_field("function_code", want.function_code, got.function_code);
            compare_field("first_value", want.first_value, got.first_value);
            compare_field("second_value", want.second_value, got.second_value);
            compare_field("third_value", want.third_value, got.third_value);
            compare_field("fourth_value", want.fourth_value, got.fourth_value);
            compare_field("byte_count", want.byte_count, got.byte_count);
            compare_field("data_out", want.data_out, got.data_out);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             data_byte = '0;
    logic                   chunk_end = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [1:0]             kind;
    logic                   last_of_run;
    logic [15:0]            transaction_id;
    logic [7:0]             function_code;
    logic [15:0]            first_value;
    logic [15:0]            second_value;
    logic [15:0]            third_value;
    logic [15:0]            fourth_value;
    logic [7:0]             byte_count;
    logic [7:0]             data_out;
    result_t                seen;

    adu_tracker tracker = new();
    bit         quiet = 1'b0;
    int         bytes_sent = 0;
    int         requests_sent = 0;
    int         settings_used = 1;

    modbus_tcp_request_parser u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .chunk_end      (chunk_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .last_of_run    (last_of_run),
        .transaction_id (transaction_id),
        .function_code  (function_code),
        .first_value    (first_value),
        .second_value   (second_value),
        .third_value    (third_value),
        .fourth_value   (fourth_value),
        .byte_count     (byte_count),
        .data_out       (data_out)
    );

    always #1 clk = ~clk;

    assign seen = {kind, last_of_run, transaction_id, function_code, first_value,
                   second_value, third_value, fourth_value, byte_count, data_out};

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_record(seen);
    end

    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic e);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        chunk_end <= e;
        do @(posedge clk); while (!in_ready);
        tracker.take_byte(b, e);
        bytes_sent++;
    endtask

    // fill < 0: random word and data bytes; tail < 0: random tail after a rejection
    task automatic send_request(input logic [7:0] unit_sel, input logic [7:0] code,
                                input int count, input int fill, input int tail);
        logic [7:0] stream [$];
        bit         cut;
        int         n_tail;
        int         n_words;
        logic       e;
        repeat (6) stream = {stream, 8'($urandom_range(0, 255))};
        stream = {stream, unit_sel};
        cut = (unit_sel != tracker.unit_addr);
        if (!cut)
        begin
            stream = {stream, code};
            cut = !(code < CODE_PAST_MASK && tracker.code_mask[code[5:0]]);
        end
        if (cut)
        begin
            n_tail = (tail < 0) ? $urandom_range(0, 3) : tail;
            repeat (n_tail) stream = {stream, 8'($urandom_range(0, 255))};
        end
        else
        begin
            n_words = (code == FC_READ_WRITE_REGS) ? 8 : 4;
            repeat (n_words)
                stream = {stream, 8'(fill < 0 ? $urandom_range(0, 255) : fill)};
            if (code == FC_WRITE_COILS || code == FC_WRITE_REGISTERS ||
                code == FC_READ_WRITE_REGS)
            begin
                stream = {stream, 8'(count)};
                repeat (count)
                    stream = {stream, 8'(fill < 0 ? $urandom_range(0, 255) : fill)};
            end
        end
        foreach (stream[i])
        begin
            if (i == stream.size() - 1)
                e = cut ? 1'b1 : 1'($urandom_range(0, 1));
            else
                e = !cut && $urandom_range(0, 7) == 0;
            send_byte(stream[i], e);
        end
        requests_sent++;
    endtask

    task automatic random_item();
        int unsigned pick;
        int          count;
        logic [7:0]  code;
        logic [7:0]  flip;
        pick = $urandom_range(0, 9);
        code = 8'($urandom_range(0, 255));
        if (pick < 7)
        begin
            case ($urandom_range(0, 3))
                0: code = FC_WRITE_COILS;
                1: code = FC_WRITE_REGISTERS;
                2: code = FC_READ_WRITE_REGS;
                default:
                begin
                    code = 8'($urandom_range(0, 63));
                    for (int k = 0; k < 64 && !tracker.code_mask[code[5:0]]; k++)
                        code = 8'($urandom_range(0, 63));
                end
            endcase
            count = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            send_request(tracker.unit_addr, code, count, -1, -1);
        end
        else if (pick == 7)
        begin
            flip = 8'($urandom_range(1, 255));
            send_request(tracker.unit_addr ^ flip, code, 0, -1, -1);
        end
        else if (pick == 8)
        begin
            if (code < CODE_PAST_MASK && tracker.code_mask[code[5:0]])
                code = code + CODE_PAST_MASK;
            send_request(tracker.unit_addr, code, 0, -1, -1);
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            // realign on a request boundary
            while (tracker.phase != PH_TID_HI || tracker.dropping)
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_reg(idx, value);
        @(posedge clk);
    endtask

    initial
    begin
        logic [7:0]  unit_sel;
        logic [63:0] mask;
        int          target;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(UNIT_ADDRESS_RESET, FC_READ_HOLDING, 0, 8'hFF, -1);
        send_request(UNIT_ADDRESS_RESET, FC_READ_INPUT, 0, 8'h00, -1);
        send_request(UNIT_ADDRESS_RESET, FC_WRITE_REGISTERS, 0, -1, -1);
        send_request(UNIT_ADDRESS_RESET, FC_WRITE_REGISTERS, 3, -1, -1);
        send_request(UNIT_ADDRESS_RESET, FC_READ_WRITE_REGS, 0, -1, -1);
        send_request(UNIT_ADDRESS_RESET, FC_READ_WRITE_REGS, 2, 8'hFF, -1);
        send_request(UNIT_ADDRESS_RESET, FC_WRITE_COILS, 0, -1, 2);
        send_request(UNIT_ADDRESS_RESET, CODE_LOWEST, 0, -1, 0);
        send_request(UNIT_ADDRESS_RESET, CODE_PAST_MASK, 0, -1, 1);
        send_request(UNIT_ADDRESS_RESET, CODE_HIGHEST, 0, -1, 3);
        send_request(8'h01, FC_READ_HOLDING, 0, -1, 3);
        send_request(8'hFF, FC_READ_HOLDING, 0, -1, 0);
        send_request(UNIT_ADDRESS_RESET, FC_WRITE_REGISTERS, 255, -1, -1);

        settle();
        write_reg(REG_UNIT_ADDRESS, 64'hFF);
        write_reg(REG_VALID_CODE_MASK, '1);
        settings_used++;
        send_request(8'hFF, FC_WRITE_COILS, 1, 8'h00, -1);
        send_request(8'hFF, CODE_LOWEST, 0, -1, -1);
        send_request(8'hFF, CODE_MASK_TOP, 0, -1, -1);
        send_request(8'hFF, CODE_PAST_MASK, 0, -1, 2);
        send_request(8'h00, FC_WRITE_REGISTERS, 0, -1, 1);

        for (int p = 0; p < 5; p++)
        begin
            unit_sel = 8'($urandom_range(0, 255));
            mask = {$urandom, $urandom};
            case (p)
                0:
                begin
                    mask[FC_WRITE_COILS]     = 1'b1;
                    mask[FC_WRITE_REGISTERS] = 1'b1;
                    mask[FC_READ_WRITE_REGS] = 1'b1;
                end
                1:
                begin
                    unit_sel = 8'hFF;
                    mask = '1;
                end
                2:
                begin
                    unit_sel = 8'h00;
                    mask = '0;
                end
                3: ;
                default:
                begin
                    mask = VALID_CODE_MASK_RESET;
                end
            endcase
            settle();
            write_reg(REG_UNIT_ADDRESS, {56'd0, unit_sel});
            write_reg(REG_VALID_CODE_MASK, mask);
            settings_used++;
            quiet = (p == 4);
            target = bytes_sent + 15;
            while (bytes_sent < target)
                random_item();
        end

        settle();
        repeat (10) @(posedge clk);
        $display("Sent %0d requests (%0d bytes) under %0d register settings;",
                 requests_sent, bytes_sent, settings_used);
        $display("checked %0d result records, %0d mismatches.", tracker.checked,
                 tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Timeout with %0d results outstanding", tracker.awaited.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
hdl/mbtcp_pkg.sv
hdl/modbus_tcp_request_parser.sv
dv/modbus_tcp_request_parser_test.sv
